>>> rtl/core/assert_macros.svh
// assertion macros shared by the deframer rtl
// sampled on clk_i, disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lpd assertion failed");

// next-cycle implication
`define LPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lpd assertion failed");

`endif

>>> rtl/core/lpd_pkg.sv
// shared types and constants of the length-prefixed deframer
// no dependencies
`timescale 1ns / 1ps

package lpd_pkg;

  localparam int unsigned HdrBytes = 6;
  localparam int unsigned LenBytes = 4;

  localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;
  localparam logic [15:0] HDR_BYTES_W   = 16'(HdrBytes);
  localparam logic [2:0]  LAST_HDR_IDX  = 3'(HdrBytes - 1);
  localparam logic [2:0]  LEN_BYTES_W   = 3'(LenBytes);

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_MAX_LEN = 1'b0;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } result_kind_e;

  // one result word from the parser
  typedef struct packed {
    logic         valid;
    result_kind_e kind;
    logic [15:0]  command;
    logic [15:0]  total_length;
    logic [7:0]   payload;
    logic         last;
  } result_t;

  // parser status for checking
  typedef struct packed {
    logic [2:0] hdr_cnt;
    logic       payload_active;
  } status_t;

endpackage

>>> rtl/core/lpd_ifs.sv
// valid/ready channel interfaces of the deframer
// depends on lpd_pkg
`timescale 1ns / 1ps

interface lpd_in_if import lpd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [15:0] frame_command;
  logic [15:0] frame_total_length;
  logic [7:0]  payload_byte;
  logic        frame_last;

  modport source (output valid, output result_kind, output frame_command,
                  output frame_total_length, output payload_byte,
                  output frame_last, input ready);
  modport sink (input valid, input result_kind, input frame_command,
                input frame_total_length, input payload_byte,
                input frame_last, output ready);
endinterface

>>> rtl/core/lpd_cfg_regs.sv
// apb register file: holds max_frame_length
// depends on lpd_pkg
`timescale 1ns / 1ps

module lpd_cfg_regs import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] max_len_o
);

  logic [15:0] max_len_q, max_len_d;
  logic        wr_en;

  assign pready = 1'b1;

  // write decode
  always_comb begin
    wr_en     = psel && penable && pwrite && (paddr[2] == CFG_IDX_MAX_LEN);
    max_len_d = wr_en ? pwdata[15:0] : max_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  // read mux
  assign prdata    = (paddr[2] == CFG_IDX_MAX_LEN) ? {16'h0000, max_len_q} : 32'h0;
  assign max_len_o = max_len_q;

endmodule

>>> rtl/core/lpd_parser.sv
// header collection, length check and payload count, one byte per cycle while accept_i is high
// depends on lpd_pkg
`timescale 1ns / 1ps

module lpd_parser import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  byte_i,
  input  logic [15:0] max_len_i,
  output result_t     result_o,
  output status_t     status_o
);

  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [15:0] len_lo_q, len_lo_d;
  logic        len_hi_q, len_hi_d;   // length bits above 16 seen nonzero
  logic [15:0] cmd_q, cmd_d;
  logic [15:0] left_q, left_d;
  logic [15:0] cmd_full;
  logic        len_ok;
  result_t     res;

  // next state and result
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    len_lo_d  = len_lo_q;
    len_hi_d  = len_hi_q;
    cmd_d     = cmd_q;
    left_d    = left_q;
    cmd_full  = {cmd_q[7:0], byte_i};
    len_ok    = !len_hi_q && (len_lo_q >= HDR_BYTES_W) && (len_lo_q <= max_len_i);
    res       = '0;
    res.kind  = KIND_HEADER;

    if (left_q != 16'd0) begin
      // payload pass-through
      left_d      = left_q - 16'd1;
      res.valid   = 1'b1;
      res.kind    = KIND_PAYLOAD;
      res.payload = byte_i;
      res.last    = (left_q == 16'd1);
    end else if (hdr_cnt_q == LAST_HDR_IDX) begin
      // sixth header byte: check length
      hdr_cnt_d = 3'd0;
      len_lo_d  = 16'd0;
      len_hi_d  = 1'b0;
      cmd_d     = 16'd0;
      res.valid = 1'b1;
      if (len_ok) begin
        left_d           = len_lo_q - HDR_BYTES_W;
        res.kind         = KIND_HEADER;
        res.command      = cmd_full;
        res.total_length = len_lo_q;
        res.last         = (len_lo_q == HDR_BYTES_W);
      end else begin
        res.kind = KIND_ERROR;
      end
    end else begin
      // collect length or command
      hdr_cnt_d = hdr_cnt_q + 3'd1;
      if (hdr_cnt_q < LEN_BYTES_W) begin
        len_hi_d = len_hi_q || (len_lo_q[15:8] != 8'd0);
        len_lo_d = {len_lo_q[7:0], byte_i};
      end else begin
        cmd_d = cmd_full;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= 3'd0;
      len_lo_q  <= 16'd0;
      len_hi_q  <= 1'b0;
      cmd_q     <= 16'd0;
      left_q    <= 16'd0;
    end else if (accept_i) begin
      hdr_cnt_q <= hdr_cnt_d;
      len_lo_q  <= len_lo_d;
      len_hi_q  <= len_hi_d;
      cmd_q     <= cmd_d;
      left_q    <= left_d;
    end
  end

  assign result_o                = res;
  assign status_o.hdr_cnt        = hdr_cnt_q;
  assign status_o.payload_active = (left_q != 16'd0);

endmodule

>>> rtl/core/lpd_out_stage.sv
// result register between the parser and the output channel
// depends on lpd_pkg and lpd_ifs
`timescale 1ns / 1ps

module lpd_out_stage import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  result_t     result_i,
  output logic        ready_o,
  lpd_out_if.source   out_o
);

  logic    valid_q, valid_d;
  result_t data_q;
  logic    load;

  // accept upstream whenever the register is empty or being drained
  assign ready_o = !valid_q || out_o.ready;
  assign load    = accept_i && result_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload word, no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid              = valid_q;
  assign out_o.result_kind        = data_q.kind;
  assign out_o.frame_command      = data_q.command;
  assign out_o.frame_total_length = data_q.total_length;
  assign out_o.payload_byte       = data_q.payload;
  assign out_o.frame_last         = data_q.last;

endmodule

>>> rtl/core/length_prefixed_deframer_unit.sv
// Length-prefixed frame parser, top level.
// Input channel in_i carries one stream byte per word. A frame is a 4-byte
// big-endian total length (header included), a 2-byte big-endian command and
// then the payload. Output channel out_o gives one header word per frame
// (kind header, command, total length, last set when the payload is empty),
// then one word per payload byte with last on the final one. A total length
// below 6 or above max_frame_length gives one error word, and parsing starts
// over on a new header at the next byte.
// Throughput: one byte per cycle while in_i.ready is high; the parser updates
// its counters in the cycle a byte is accepted. A result is registered and
// appears on out_o in the cycle after the byte that causes it. Header bytes
// other than the sixth make no output word.
// When out_o stalls, the result register holds its word and in_i.ready drops
// until it is taken; a byte that makes no word is still taken as long as the
// register is empty or draining.
// Reset clears the header and payload counters and sets max_frame_length to
// 65535 (APB byte address 0). Configure only while the block is idle.
// depends on lpd_pkg, lpd_ifs, lpd_cfg_regs, lpd_parser, lpd_out_stage
`timescale 1ns / 1ps
`include "assert_macros.svh"

module length_prefixed_deframer_unit import lpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lpd_in_if.sink      in_i,
  lpd_out_if.source   out_o
);

  logic [15:0] max_len;
  logic        in_ready;
  logic        in_accept;
  result_t     result;
  status_t     status;

  assign in_i.ready = in_ready;
  assign in_accept  = in_i.valid && in_ready;

  // configuration registers
  lpd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_len_o (max_len)
  );

  // parsing logic
  lpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .byte_i    (in_i.stream_byte),
    .max_len_i (max_len),
    .result_o  (result),
    .status_o  (status)
  );

  // result register
  lpd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .result_i (result),
    .ready_o  (in_ready),
    .out_o    (out_o)
  );

  // checks
  `LPD_ASSERT_IMP(a_payload_no_hdr, status.payload_active, status.hdr_cnt == 3'd0)
  `LPD_ASSERT_NXT(a_hdr_done_gives_word,
                  in_accept && !status.payload_active && status.hdr_cnt == LAST_HDR_IDX,
                  out_o.valid)
  `LPD_ASSERT_IMP(a_error_clean, out_o.valid && out_o.result_kind == KIND_ERROR,
                  !out_o.frame_last && out_o.frame_total_length == 16'd0)
  `LPD_ASSERT_IMP(a_header_len_min, out_o.valid && out_o.result_kind == KIND_HEADER,
                  out_o.frame_total_length >= HDR_BYTES_W)

endmodule
